@@ rtl/core/nhrc_pkg.sv @@
`default_nettype none
package nhrc_pkg;

  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  localparam int unsigned FLAG_FIN = 0;
  localparam int unsigned FLAG_SYN = 1;
  localparam int unsigned FLAG_RST = 2;

  typedef enum logic [2:0] {
    REG_ORIG_SRC_ADDR = 3'd0,
    REG_ORIG_DST_ADDR = 3'd1,
    REG_ORIG_SRC_PORT = 3'd2,
    REG_ORIG_DST_PORT = 3'd3,
    REG_NEW_SRC_ADDR  = 3'd4,
    REG_NEW_DST_ADDR  = 3'd5,
    REG_NEW_SRC_PORT  = 3'd6,
    REG_NEW_DST_PORT  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [31:0] new_src_addr;
    logic [31:0] new_dst_addr;
    logic [15:0] new_src_port;
    logic [15:0] new_dst_port;
    logic [15:0] ip_delta;
    logic [15:0] l4_delta;
  } map_t;

  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] ip_checksum;
    logic [7:0]  protocol;
    logic        first_fragment;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [15:0] l4_checksum;
    logic [7:0]  tcp_flag_bits;
  } in_item_t;

  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] ip_checksum;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [15:0] l4_checksum;
    logic        ports_rewritten;
    logic        session_done;
    logic        flow_over;
  } out_item_t;

  typedef struct packed {
    logic session_ended;
    logic flow_ended;
  } marks_t;

  // ~from + to for one 16-bit word, widened for summing
  function automatic logic [19:0] word_delta(input logic [15:0] from, input logic [15:0] to);
    logic [16:0] s;
    s = {1'b0, ~from} + {1'b0, to};
    return {3'b000, s};
  endfunction

  function automatic logic [15:0] fold16(input logic [19:0] s);
    logic [16:0] a;
    logic [16:0] b;
    a = {1'b0, s[15:0]} + {13'b0, s[19:16]};
    b = {1'b0, a[15:0]} + {16'b0, a[16]};
    return b[15:0];
  endfunction

  function automatic logic [15:0] apply_delta(input logic [15:0] csum,
                                              input logic [15:0] delta);
    logic [19:0] s;
    s = {4'b0, ~csum} + {4'b0, delta};
    return ~fold16(s);
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/nat_header_rewrite_checksum_top.sv @@
// NAT header rewrite with incremental checksum update. Every packet header
// gets the configured mapped addresses and an updated IPv4 checksum; TCP or
// UDP first fragments also get the mapped ports and an updated L4 checksum
// (a zero UDP checksum stays zero), and TCP flags drive the session-over and
// flow-over marks. While not stalled, one request is accepted per clock; its
// result passes through the input register and then the result register:
// the rewrite and checksum folds form one combinational stage between the
// two. A stalled result holds the input back. The checksum deltas are kept
// in their own register, loaded from the mapping registers. The user must
// write the registers over the APB port only while no request is in flight;
// the block itself does not enforce this.
`default_nettype none
module nat_header_rewrite_checksum_top
  import nhrc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [31:0]           in_src_addr,
  input  wire logic [31:0]           in_dst_addr,
  input  wire logic [15:0]           in_ip_checksum,
  input  wire logic [7:0]            in_protocol,
  input  wire logic                  in_first_fragment,
  input  wire logic [15:0]           in_src_port,
  input  wire logic [15:0]           in_dst_port,
  input  wire logic [15:0]           in_l4_checksum,
  input  wire logic [7:0]            in_tcp_flag_bits,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [31:0]                out_src_addr,
  output logic [31:0]                out_dst_addr,
  output logic [15:0]                out_ip_checksum,
  output logic [15:0]                out_src_port,
  output logic [15:0]                out_dst_port,
  output logic [15:0]                out_l4_checksum,
  output logic                       out_ports_rewritten,
  output logic                       out_session_done,
  output logic                       out_flow_over,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready
);

  map_t      map;
  in_item_t  s1_r;
  logic      s1_v_r;
  out_item_t out_r;
  logic      out_v_r;
  out_item_t res;
  marks_t    marks_r;
  marks_t    marks_nxt;
  logic      out_adv;
  logic      s1_fire;

  nhrc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .map     (map)
  );

  nhrc_rewrite u_rewrite (
    .item      (s1_r),
    .map       (map),
    .marks     (marks_r),
    .res       (res),
    .marks_nxt (marks_nxt)
  );

  assign out_adv  = ~out_v_r | ~out_stall;
  assign s1_fire  = s1_v_r & out_adv;
  assign in_stall = s1_v_r & ~out_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      marks_r <= '0;
    end else begin
      if (!in_stall) begin
        s1_v_r <= in_valid;
      end
      if (out_adv) begin
        out_v_r <= s1_v_r;
      end
      if (s1_fire) begin
        marks_r <= marks_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_r.src_addr       <= in_src_addr;
      s1_r.dst_addr       <= in_dst_addr;
      s1_r.ip_checksum    <= in_ip_checksum;
      s1_r.protocol       <= in_protocol;
      s1_r.first_fragment <= in_first_fragment;
      s1_r.src_port       <= in_src_port;
      s1_r.dst_port       <= in_dst_port;
      s1_r.l4_checksum    <= in_l4_checksum;
      s1_r.tcp_flag_bits  <= in_tcp_flag_bits;
    end
    if (s1_fire) begin
      out_r <= res;
    end
  end

  assign out_valid           = out_v_r;
  assign out_src_addr        = out_r.src_addr;
  assign out_dst_addr        = out_r.dst_addr;
  assign out_ip_checksum     = out_r.ip_checksum;
  assign out_src_port        = out_r.src_port;
  assign out_dst_port        = out_r.dst_port;
  assign out_l4_checksum     = out_r.l4_checksum;
  assign out_ports_rewritten = out_r.ports_rewritten;
  assign out_session_done    = out_r.session_done;
  assign out_flow_over       = out_r.flow_over;

endmodule
`default_nettype wire

@@ rtl/core/nhrc_cfg.sv @@
`default_nettype none
module nhrc_cfg
  import nhrc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready,
  output map_t                       map
);

  logic [31:0] orig_src_addr_r, orig_dst_addr_r, new_src_addr_r, new_dst_addr_r;
  logic [15:0] orig_src_port_r, orig_dst_port_r, new_src_port_r, new_dst_port_r;
  reg_idx_t    idx;
  logic        wr_en;
  logic [19:0] raw_ip;
  logic [19:0] raw_l4;
  logic [15:0] ip_delta_nxt;
  logic [15:0] l4_delta_nxt;
  logic [15:0] ip_delta_r;
  logic [15:0] l4_delta_r;

  assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      orig_src_addr_r <= '0;
      orig_dst_addr_r <= '0;
      orig_src_port_r <= '0;
      orig_dst_port_r <= '0;
      new_src_addr_r  <= '0;
      new_dst_addr_r  <= '0;
      new_src_port_r  <= '0;
      new_dst_port_r  <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_ORIG_SRC_ADDR: orig_src_addr_r <= pwdata;
        REG_ORIG_DST_ADDR: orig_dst_addr_r <= pwdata;
        REG_ORIG_SRC_PORT: orig_src_port_r <= pwdata[15:0];
        REG_ORIG_DST_PORT: orig_dst_port_r <= pwdata[15:0];
        REG_NEW_SRC_ADDR:  new_src_addr_r  <= pwdata;
        REG_NEW_DST_ADDR:  new_dst_addr_r  <= pwdata;
        REG_NEW_SRC_PORT:  new_src_port_r  <= pwdata[15:0];
        REG_NEW_DST_PORT:  new_dst_port_r  <= pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ORIG_SRC_ADDR: prdata = orig_src_addr_r;
      REG_ORIG_DST_ADDR: prdata = orig_dst_addr_r;
      REG_ORIG_SRC_PORT: prdata = {16'b0, orig_src_port_r};
      REG_ORIG_DST_PORT: prdata = {16'b0, orig_dst_port_r};
      REG_NEW_SRC_ADDR:  prdata = new_src_addr_r;
      REG_NEW_DST_ADDR:  prdata = new_dst_addr_r;
      REG_NEW_SRC_PORT:  prdata = {16'b0, new_src_port_r};
      REG_NEW_DST_PORT:  prdata = {16'b0, new_dst_port_r};
    endcase
  end

  // address words high then low, ports added on top for l4
  assign raw_ip = word_delta(orig_src_addr_r[31:16], new_src_addr_r[31:16])
                + word_delta(orig_src_addr_r[15:0],  new_src_addr_r[15:0])
                + word_delta(orig_dst_addr_r[31:16], new_dst_addr_r[31:16])
                + word_delta(orig_dst_addr_r[15:0],  new_dst_addr_r[15:0]);
  assign raw_l4 = raw_ip
                + word_delta(orig_src_port_r, new_src_port_r)
                + word_delta(orig_dst_port_r, new_dst_port_r);

  assign ip_delta_nxt = fold16(raw_ip);
  assign l4_delta_nxt = fold16(raw_l4);

  // deltas depend on the mapping only, keep them off the request path
  always_ff @(posedge clk) begin
    ip_delta_r <= ip_delta_nxt;
    l4_delta_r <= l4_delta_nxt;
  end

  assign map.new_src_addr = new_src_addr_r;
  assign map.new_dst_addr = new_dst_addr_r;
  assign map.new_src_port = new_src_port_r;
  assign map.new_dst_port = new_dst_port_r;
  assign map.ip_delta     = ip_delta_r;
  assign map.l4_delta     = l4_delta_r;

endmodule
`default_nettype wire

@@ rtl/core/nhrc_rewrite.sv @@
`default_nettype none
module nhrc_rewrite
  import nhrc_pkg::*;
(
  input  wire in_item_t item,
  input  wire map_t     map,
  input  wire marks_t   marks,
  output out_item_t     res,
  output marks_t        marks_nxt
);

  logic is_tcp;
  logic is_udp;
  logic rw;

  assign is_tcp = (item.protocol == PROTO_TCP);
  assign is_udp = (item.protocol == PROTO_UDP);
  assign rw     = item.first_fragment & (is_tcp | is_udp);

  always_comb begin
    marks_nxt = marks;
    if (rw && is_tcp) begin
      priority if (item.tcp_flag_bits[FLAG_RST]) begin
        marks_nxt.session_ended = 1'b1;
      end else if (item.tcp_flag_bits[FLAG_FIN]) begin
        marks_nxt.flow_ended = 1'b1;
      end else if (item.tcp_flag_bits[FLAG_SYN]) begin
        marks_nxt.flow_ended = 1'b0;
      end
    end
  end

  always_comb begin
    res.src_addr        = map.new_src_addr;
    res.dst_addr        = map.new_dst_addr;
    res.ip_checksum     = apply_delta(item.ip_checksum, map.ip_delta);
    res.src_port        = rw ? map.new_src_port : item.src_port;
    res.dst_port        = rw ? map.new_dst_port : item.dst_port;
    // zero udp checksum means none, keep it
    if (rw && (is_tcp || item.l4_checksum != 16'h0000)) begin
      res.l4_checksum = apply_delta(item.l4_checksum, map.l4_delta);
    end else begin
      res.l4_checksum = item.l4_checksum;
    end
    res.ports_rewritten = rw;
    res.session_done    = marks_nxt.session_ended;
    res.flow_over       = marks_nxt.flow_ended;
  end

endmodule
`default_nettype wire
